FILE: rtl/core/assert_macros.svh
// assertion macros shared by the semaphore rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSEM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSEM_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CSEM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSEM_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: rtl/core/csem_pkg.sv
// types and constants of the counting semaphore with priority wait queue
// no dependencies; imported by every module of the block
package csem_pkg;

    localparam int MAX_WAITERS = 16;
    localparam int ID_BITS     = 8;
    localparam int PRIO_BITS   = 8;
    localparam int CNT_W       = 16;
    localparam int USED_W      = $clog2(MAX_WAITERS + 1);

    // command codes
    typedef enum logic [1:0] {
        CMD_WAIT    = 2'd0,
        CMD_SIGNAL  = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_TIMEOUT  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // configuration register indexes
    localparam logic [1:0] REG_START_COUNT = 2'd0;
    localparam logic [1:0] REG_COUNT_LIMIT = 2'd1;

    // operation broadcast to every queue cell
    typedef enum logic [1:0] {
        Q_HOLD,
        Q_INSERT,
        Q_REMOVE,
        Q_POP
    } q_op_t;

    typedef struct packed {
        q_op_t                 op;
        logic [ID_BITS-1:0]    id;
        logic [PRIO_BITS-1:0]  prio;
    } q_ctrl_t;

    // one queue entry as handed between neighbor cells
    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [PRIO_BITS-1:0]  prio;
    } entry_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

FILE: rtl/core/csem_cell.sv
// one slot of the shifting priority wait queue
// depends on csem_pkg; a row of these is built by csem_queue
module csem_cell
    import csem_pkg::*;
(
    input  logic    clk,
    input  q_ctrl_t ctrl,
    input  logic    occupied,
    input  logic    left_ge,
    input  logic    left_found,
    input  entry_t  left_entry,
    input  entry_t  right_entry,
    output logic    ge,
    output logic    found,
    output entry_t  entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // ordering and match flags passed down the row
    assign ge    = left_ge & occupied & (entry_reg.prio >= ctrl.prio);
    assign found = left_found | (occupied & (entry_reg.id == ctrl.id));

    // slot update: keep, load new, take from left, or take from right
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            Q_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        entry_next.id   = ctrl.id;
                        entry_next.prio = ctrl.prio;
                    end
                    else
                    begin
                        entry_next = left_entry;
                    end
                end
            end
            Q_REMOVE:
            begin
                if (found)
                begin
                    entry_next = right_entry;
                end
            end
            Q_POP:
            begin
                entry_next = right_entry;
            end
            Q_HOLD:
            begin
                entry_next = entry_reg;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/core/csem_queue.sv
// row of queue cells holding waiters in priority order, head at slot 0
// depends on csem_pkg and csem_cell
module csem_queue
    import csem_pkg::*;
(
    input  logic                clk,
    input  q_ctrl_t             ctrl,
    input  logic [USED_W-1:0]   used,
    output logic [ID_BITS-1:0]  head_id,
    output logic                found
);

    logic   [MAX_WAITERS:0]   ge_link;
    logic   [MAX_WAITERS:0]   found_link;
    entry_t [MAX_WAITERS-1:0] entries;
    entry_t                   tail_fill;

    assign ge_link[0]    = 1'b1;
    assign found_link[0] = 1'b0;
    assign tail_fill     = '0;

    // the chain of cells
    for (genvar i = 0; i < MAX_WAITERS; i++)
    begin : g_cell
        logic   occ;
        entry_t left_e;
        entry_t right_e;

        assign occ     = (used > USED_W'(i));
        assign left_e  = (i == 0) ? tail_fill : entries[(i == 0) ? 0 : i - 1];
        assign right_e = (i == MAX_WAITERS - 1) ? tail_fill
                         : entries[(i == MAX_WAITERS - 1) ? i : i + 1];

        csem_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (occ),
            .left_ge     (ge_link[i]),
            .left_found  (found_link[i]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .ge          (ge_link[i+1]),
            .found       (found_link[i+1]),
            .entry       (entries[i])
        );
    end

    assign head_id = entries[0].id;
    assign found   = found_link[MAX_WAITERS];

endmodule

FILE: rtl/core/counting_semaphore_priority_waitq_unit.sv
// top level of the counting semaphore with priority wait queue
// depends on csem_pkg, csem_queue and assert_macros.svh
//
//  channel   | direction | fields (lowest bit up)
//  s_axis    | in        | tdata: task_id[7:0] task_priority[15:8] no_wait[16]; tuser: cmd
//  m_axis    | out       | tdata: status woken_valid woken_task count_now waiter_total
//  cfg       | in        | index 0 start count, index 1 count limit, one write per cycle
//
// each item is first registered, then updates the cell row and the count when the output
// register can take its result; the next item can be taken in the cycle after that update
// the result waits in an output register; a stalled output holds the item in execute
// reset empties the queue and clears count and configuration registers; no clearing pass
// a write to either configuration register reloads the count and empties the queue
`include "assert_macros.svh"
module counting_semaphore_priority_waitq_unit
    import csem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id, task_priority, no_wait
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status, woken_valid, woken_task, count_now, waiter_total
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]     init_reg, init_next;
    logic [CNT_W-1:0]     max_reg, max_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [USED_W-1:0]    used_reg, used_next;

    logic [1:0]           cmd_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic                 nowait_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [39:0]          out_data_reg;

    logic                 accept;
    logic                 fire;
    q_ctrl_t              q_ctrl;
    logic [ID_BITS-1:0]   head_id;
    logic                 q_found;

    status_t              st;
    logic                 wvalid;
    logic [ID_BITS-1:0]   wtask;
    logic [CNT_W-1:0]     op_count;
    logic [USED_W-1:0]    op_used;
    q_op_t                op;
    logic [CNT_W-1:0]     reload_count;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign fire     = (state_reg == S_EXEC) & (~out_valid_reg | m_tready);

    // state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser;
            id_reg     <= s_tdata[ID_BITS-1:0];
            prio_reg   <= s_tdata[8 +: PRIO_BITS];
            nowait_reg <= s_tdata[16];
        end
    end

    // command decode and semaphore arithmetic
    always_comb
    begin
        st       = ST_OK;
        wvalid   = 1'b0;
        wtask    = '0;
        op_count = count_reg;
        op_used  = used_reg;
        op       = Q_HOLD;
        unique case (cmd_reg)
            CMD_WAIT:
            begin
                priority if (count_reg != '0)
                begin
                    op_count = count_reg - 1'b1;
                end
                else if (nowait_reg)
                begin
                    st = ST_TIMEOUT;
                end
                else if (used_reg >= USED_W'(MAX_WAITERS))
                begin
                    st = ST_FULL;
                end
                else
                begin
                    op      = Q_INSERT;
                    op_used = used_reg + 1'b1;
                    st      = ST_BLOCKED;
                end
            end
            CMD_SIGNAL:
            begin
                priority if (used_reg != '0)
                begin
                    op      = Q_POP;
                    op_used = used_reg - 1'b1;
                    wvalid  = 1'b1;
                    wtask   = head_id;
                end
                else if ((max_reg != '0 && count_reg >= max_reg) || (&count_reg))
                begin
                    st = ST_OVERFLOW;
                end
                else
                begin
                    op_count = count_reg + 1'b1;
                end
            end
            CMD_TIMEOUT:
            begin
                if (q_found)
                begin
                    op      = Q_REMOVE;
                    op_used = used_reg - 1'b1;
                    st      = ST_TIMEOUT;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
    end

    // queue control, active only in the update cycle
    always_comb
    begin
        q_ctrl.op   = fire ? op : Q_HOLD;
        q_ctrl.id   = id_reg;
        q_ctrl.prio = prio_reg;
    end

    csem_queue u_queue (
        .clk     (clk),
        .ctrl    (q_ctrl),
        .used    (used_reg),
        .head_id (head_id),
        .found   (q_found)
    );

    // configuration registers and reload
    always_comb
    begin
        init_next = init_reg;
        max_next  = max_reg;
        if (cfg_we && cfg_addr == REG_START_COUNT)
        begin
            init_next = cfg_data;
        end
        if (cfg_we && cfg_addr == REG_COUNT_LIMIT)
        begin
            max_next = cfg_data;
        end
        reload_count = (max_next != '0 && init_next > max_next) ? max_next : init_next;
    end

    // count and fill level
    always_comb
    begin
        count_next = count_reg;
        used_next  = used_reg;
        priority if (cfg_we && (cfg_addr == REG_START_COUNT || cfg_addr == REG_COUNT_LIMIT))
        begin
            count_next = reload_count;
            used_next  = '0;
        end
        else if (fire)
        begin
            count_next = op_count;
            used_next  = op_used;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            max_reg   <= '0;
            count_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            init_reg  <= init_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {7'd0, op_used, op_count, wtask, wvalid, st};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    `CSEM_NEVER(a_fill, clk, rst_n, used_reg > USED_W'(MAX_WAITERS), "fill beyond depth")
    `CSEM_NEVER(a_excl, clk, rst_n, count_reg != '0 && used_reg != '0, "units and waiters")
    `CSEM_ASSERT(a_grow, clk, rst_n, st == ST_BLOCKED |-> op_used > used_reg, "no growth")
    `CSEM_ASSERT(a_woken, clk, rst_n, m_tvalid & m_tdata[3] |-> m_tdata[2:0] == ST_OK, "bad status")
    `CSEM_ASSERT(a_exec, clk, rst_n, accept |=> state_reg == S_EXEC, "item not executed")

endmodule

FILE: sim/csem_monitor.sv
// result checker for the counting semaphore with priority wait queue
// keeps its own copy of the count, the limits and the wait queue, predicts each result
// from the items and register writes it sees and compares it with the block; needs csem_pkg
module csem_monitor
    import csem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // task_id, task_priority, no_wait
    input  logic [1:0]  s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // status, woken_valid, woken_task, count_now, waiter_total
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    typedef struct {
        status_t              status;
        logic                 woken_valid;
        logic [ID_BITS-1:0]   woken_task;
        logic [CNT_W-1:0]     count_now;
        logic [USED_W-1:0]    waiter_total;
    } sem_result_t;

    // shadow of the block state
    logic [CNT_W-1:0]     init_reg;
    logic [CNT_W-1:0]     max_reg;
    logic [CNT_W-1:0]     sem_count;
    logic [ID_BITS-1:0]   wait_ids   [MAX_WAITERS];
    logic [PRIO_BITS-1:0] wait_prios [MAX_WAITERS];
    int                   waiters;

    sem_result_t awaited_results [$];
    int          errors = 0;

    // count back to its start value, clamped to a nonzero limit; queue emptied
    function automatic void reload_count();
        sem_count = (max_reg != '0 && init_reg > max_reg) ? max_reg : init_reg;
        waiters   = 0;
    endfunction

    // close the gap left by a leaving waiter
    function automatic void drop_waiter(int pos);
        for (int i = pos; i < waiters - 1; i++)
        begin
            wait_ids[i]   = wait_ids[i + 1];
            wait_prios[i] = wait_prios[i + 1];
        end
        waiters--;
    endfunction

    // one semaphore operation on the shadow state
    function automatic sem_result_t apply_sem_op(logic [1:0] cmd, logic [ID_BITS-1:0] id,
                                                 logic [PRIO_BITS-1:0] prio, logic nowait);
        sem_result_t r;
        int          pos;
        bit          found;
        r.status      = ST_OK;
        r.woken_valid = 1'b0;
        r.woken_task  = '0;
        found         = 1'b0;
        case (cmd)
            CMD_WAIT:
            begin
                if (sem_count != '0)
                    sem_count--;
                else if (nowait)
                    r.status = ST_TIMEOUT;
                else if (waiters >= MAX_WAITERS)
                    r.status = ST_FULL;
                else
                begin
                    // behind every waiter of equal or higher priority
                    pos = 0;
                    while (pos < waiters && wait_prios[pos] >= prio)
                        pos++;
                    for (int i = waiters; i > pos; i--)
                    begin
                        wait_ids[i]   = wait_ids[i - 1];
                        wait_prios[i] = wait_prios[i - 1];
                    end
                    wait_ids[pos]   = id;
                    wait_prios[pos] = prio;
                    waiters++;
                    r.status = ST_BLOCKED;
                end
            end
            CMD_SIGNAL:
            begin
                if (waiters > 0)
                begin
                    r.woken_valid = 1'b1;
                    r.woken_task  = wait_ids[0];
                    drop_waiter(0);
                end
                else if ((max_reg != '0 && sem_count >= max_reg) || sem_count == '1)
                    r.status = ST_OVERFLOW;
                else
                    sem_count++;
            end
            CMD_TIMEOUT:
            begin
                // only the entry nearest the head leaves
                for (int i = 0; i < waiters && !found; i++)
                begin
                    if (wait_ids[i] == id)
                    begin
                        drop_waiter(i);
                        r.status = ST_TIMEOUT;
                        found    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count_now    = sem_count;
        r.waiter_total = USED_W'(waiters);
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // results first, then register writes, then newly taken items
    always @(posedge clk)
    begin
        sem_result_t want;
        if (!rst_n)
        begin
            init_reg = '0;
            max_reg  = '0;
            reload_count();
            awaited_results.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result %h with no item outstanding", m_tdata);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 16'(want.status), 16'(m_tdata[2:0]));
                    check_field("woken_valid", 16'(want.woken_valid), 16'(m_tdata[3]));
                    check_field("woken_task", 16'(want.woken_task), 16'(m_tdata[11:4]));
                    check_field("count_now", want.count_now, m_tdata[27:12]);
                    check_field("waiter_total", 16'(want.waiter_total), 16'(m_tdata[32:28]));
                end
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_START_COUNT)
                begin
                    init_reg = cfg_data;
                    reload_count();
                end
                else if (cfg_addr == REG_COUNT_LIMIT)
                begin
                    max_reg = cfg_data;
                    reload_count();
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_sem_op(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                                       s_tdata[16]));
        end
        mismatches  <= errors;
        outstanding <= awaited_results.size();
    end

endmodule

FILE: sim/tb.sv
// testbench top for the counting semaphore with priority wait queue
// drives items, register writes and output stalls; csem_monitor does the checking
// depends on csem_pkg, csem_monitor and the block itself
module tb;
    import csem_pkg::*;

    localparam logic [1:0] CMD_NONE    = 2'd3;   // command code the block ignores
    localparam logic [1:0] REG_SPARE   = 2'd3;   // index with no register behind it
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         LONG_HOLD   = 300;
    localparam int         PHASES      = 12;
    localparam int         PHASE_ITEMS = 135;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // task_id, task_priority, no_wait
    logic [1:0]  s_tuser  = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status, woken_valid, woken_task, count_now, waiter_total
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    int mismatches;
    int outstanding;
    int cycles      = 0;
    int sent        = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    bit tx_rush     = 1'b0;
    bit rx_rush     = 1'b0;

    logic [ID_BITS-1:0]   id_pool   [8];
    logic [PRIO_BITS-1:0] prio_pool [4];

    always #1 clk = ~clk;

    counting_semaphore_priority_waitq_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    csem_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall per item, long hold on request
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                stall = LONG_HOLD;
                holds_done++;
            end
            else
                stall = rx_rush ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(logic [1:0] cmd, logic [7:0] id, logic [7:0] prio, logic nowait);
        int gap;
        gap = tx_rush ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, nowait, prio, id};
        do @(posedge clk); while (!s_tready);
        if (cmd != CMD_NONE)
            sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic quiesce();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [15:0] init_val, logic [15:0] max_val);
        quiesce();
        write_reg(REG_START_COUNT, init_val);
        write_reg(REG_COUNT_LIMIT, max_val);
    endtask

    // ids mostly from a small pool so timeouts and duplicates hit queued tasks
    task automatic send_random(bit wait_heavy);
        int         pick;
        logic [1:0] cmd;
        logic [7:0] id;
        logic [7:0] prio;
        logic       nowait;
        pick = $urandom_range(0, 99);
        if (wait_heavy)
            cmd = pick < 65 ? CMD_WAIT : pick < 80 ? CMD_SIGNAL : pick < 96 ? CMD_TIMEOUT : CMD_NONE;
        else
            cmd = pick < 25 ? CMD_WAIT : pick < 70 ? CMD_SIGNAL : pick < 96 ? CMD_TIMEOUT : CMD_NONE;
        id     = ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 7)] : 8'($urandom);
        prio   = ($urandom_range(0, 1) != 0) ? prio_pool[$urandom_range(0, 3)] : 8'($urandom);
        nowait = ($urandom_range(0, 6) == 0);
        send_item(cmd, id, prio, nowait);
    endtask

    // stimulus
    initial
    begin
        int          goal;
        logic [15:0] init_val;
        logic [15:0] max_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty count, priority order, duplicates, timeouts, unknown command
        send_item(CMD_WAIT, 8'hFF, 8'h00, 1'b1);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);
        send_item(CMD_WAIT, 8'h00, 8'hFF, 1'b1);
        send_item(CMD_WAIT, 8'h01, 8'h05, 1'b0);
        send_item(CMD_WAIT, 8'h02, 8'hFF, 1'b0);
        send_item(CMD_WAIT, 8'h03, 8'h05, 1'b0);
        send_item(CMD_WAIT, 8'h04, 8'h00, 1'b0);
        send_item(CMD_WAIT, 8'h01, 8'hC8, 1'b0);
        send_item(CMD_TIMEOUT, 8'h01, 8'h00, 1'b0);
        send_item(CMD_TIMEOUT, 8'h77, 8'h00, 1'b0);
        send_item(CMD_NONE, 8'hFF, 8'hFF, 1'b1);
        repeat (5) send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);

        // unlimited count at its top
        configure(16'hFFFF, 16'h0000);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);
        send_item(CMD_WAIT, 8'h10, 8'h80, 1'b0);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);

        // start count clamped to a low limit
        configure(16'hFFFF, 16'h0001);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);
        send_item(CMD_WAIT, 8'h20, 8'h01, 1'b0);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);
        send_item(CMD_SIGNAL, 8'h00, 8'h00, 1'b0);

        // random phases, each under its own register setting
        sent = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 6)
                0:
                begin
                    init_val = 16'h0000;
                    max_val  = 16'h0000;
                end
                1:
                begin
                    init_val = 16'($urandom_range(1, 6));
                    max_val  = 16'h0000;
                end
                2:
                begin
                    init_val = 16'hFFFF;
                    max_val  = 16'h0000;
                end
                3:
                begin
                    init_val = 16'hFFFF;
                    max_val  = 16'($urandom_range(1, 8));
                end
                4:
                begin
                    init_val = 16'($urandom_range(0, 10));
                    max_val  = 16'hFFFF;
                end
                default:
                begin
                    init_val = 16'($urandom);
                    max_val  = 16'($urandom);
                end
            endcase
            configure(init_val, max_val);
            if (p % 6 == 5)
                write_reg(REG_SPARE, 16'($urandom));

            foreach (id_pool[i])
                id_pool[i] = 8'($urandom);
            prio_pool[0] = 8'h00;
            prio_pool[1] = 8'hFF;
            prio_pool[2] = 8'($urandom);
            prio_pool[3] = 8'($urandom);

            // output held off while items keep coming, so the block backs up
            if (p == 1)
            begin
                holds_asked++;
                tx_rush = 1'b1;
                repeat (30) send_random(1'b1);
                quiesce();
            end

            goal = sent + PHASE_ITEMS;
            while (sent < goal)
            begin
                tx_rush = ($urandom_range(0, 3) == 0);
                rx_rush = ($urandom_range(0, 3) == 0);
                repeat ($urandom_range(8, 40)) send_random($urandom_range(0, 1));
                if ($urandom_range(0, 4) == 0)
                    quiesce();
            end
        end

        // drain, let the pipeline settle, then report
        quiesce();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/csem_pkg.sv
rtl/core/csem_cell.sv
rtl/core/csem_queue.sv
rtl/core/counting_semaphore_priority_waitq_unit.sv
sim/csem_monitor.sv
sim/tb.sv
